/* design/assert_macros.svh */
// Assertion macros shared by the tracker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

/* design/rwot_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwot_pkg
// Shared types and constants of the recent write overlap tracker.
// ----------------------------------------------------------------------------
package rwot_pkg;
   localparam int TRACK_DEPTH = 16;
   localparam int MAX_RANGE_BLOCKS = 1024;
   localparam int BLOCK_INDEX_BITS = 48;
   localparam int SLOT_BITS = (TRACK_DEPTH > 1) ? $clog2(TRACK_DEPTH) : 1;
   localparam int FILL_BITS = $clog2(TRACK_DEPTH + 1);
   localparam int COUNT_BITS = 11;
   localparam int COVER_BITS = $clog2(MAX_RANGE_BLOCKS + 1);
   localparam int ENTRY_BITS = 64 + BLOCK_INDEX_BITS + COUNT_BITS;

   typedef enum logic [1:0] {
      OP_CHECK = 2'd0, OP_ADD = 2'd1, OP_CLEAR = 2'd2, OP_NONE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_NONE = 3'd0, ST_PARTIAL = 3'd1, ST_COMPLETE = 3'd2, ST_TOO_OLD = 3'd3,
      ST_REPEATED = 3'd4, ST_RECORDED = 3'd5, ST_DUPLICATE = 3'd6, ST_CLEARED = 3'd7
   } status_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [63:0] request_id;
      logic [47:0] range_start;
      logic [10:0] block_count;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] overlap_id;
      logic [47:0] overlap_start;
      logic [10:0] overlap_count;
      logic        evicted;
      logic [63:0] evicted_id;
   } rsp_type;

   // normalized request between front and back
   typedef struct packed {
      op_type                      op;
      logic [63:0]                 id;
      logic [BLOCK_INDEX_BITS-1:0] start;
      logic [COUNT_BITS-1:0]       len;
   } job_type;
endpackage

/* design/rwot_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwot_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rwot_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [((DEPTH>1)?$clog2(DEPTH):1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [((DEPTH>1)?$clog2(DEPTH):1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

/* design/rwot_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwot_front
// Accept requests, normalize the range and hold one job for the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module rwot_front import rwot_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    job_valid,
   output job_type job,
   input  logic    job_take,
   input  logic    back_idle
);
   localparam logic [BLOCK_INDEX_BITS-1:0] TOP = '1;
   logic    full_ff, full_in;
   job_type job_ff, job_in;
   logic [COUNT_BITS-1:0] n;
   logic [BLOCK_INDEX_BITS-1:0] room;

   always_comb begin
      n = req_data.block_count;
      if (n == '0) n = COUNT_BITS'(1);
      if (n > COUNT_BITS'(MAX_RANGE_BLOCKS)) n = COUNT_BITS'(MAX_RANGE_BLOCKS);
      room = TOP - req_data.range_start[BLOCK_INDEX_BITS-1:0];
      if (room < BLOCK_INDEX_BITS'(n - 1'b1)) n = COUNT_BITS'(room + 1'b1);
      job_in = job_ff;
      full_in = full_ff;
      if (job_take) full_in = 1'b0;
      if (start && !busy) begin
         full_in = 1'b1;
         job_in.op = op_type'(req_data.operation);
         job_in.id = req_data.request_id;
         job_in.start = req_data.range_start[BLOCK_INDEX_BITS-1:0];
         job_in.len = n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) full_ff <= 1'b0;
      else full_ff <= full_in;
      job_ff <= job_in;
   end

   assign busy = full_ff || !back_idle;
   assign job_valid = full_ff;
   assign job = job_ff;

   `ASSERT_IMPL(a_take_full, job_take, full_ff, "take without job")
   `ASSERT_NEXT(a_accept_fills, start && !busy, full_ff, "accepted request lost")
endmodule

/* design/rwot_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwot_back
// Execute jobs: scan the ring one entry a cycle, build coverage, update ring.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module rwot_back import rwot_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   input  job_type job,
   output logic    job_take,
   output logic    idle,
   output logic    rsp_valid,
   output rsp_type rsp_data
);
   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_type;
   localparam int CNT_BITS = SLOT_BITS + 1;

   state_type state_ff;
   job_type   cur_ff;
   logic [SLOT_BITS-1:0] wslot_ff;
   logic [FILL_BITS-1:0] fill_ff;
   logic [CNT_BITS-1:0]  issue_ff;
   logic                 rvalid_ff;
   logic [63:0]          min_ff, best_id_ff, old_id_ff;
   logic [BLOCK_INDEX_BITS-1:0] best_start_ff;
   logic [COUNT_BITS-1:0] best_cnt_ff;
   logic                 found_ff, larger_ff, dup_ff;
   logic [MAX_RANGE_BLOCKS-1:0] cover_ff;
   logic                 out_v_ff;
   rsp_type              out_ff, out_in;

   logic                 wr_en;
   logic [ENTRY_BITS-1:0] rd_data;
   logic [SLOT_BITS-1:0] rd_addr;
   logic [SLOT_BITS-1:0] rd_slot_ff;

   assign rd_addr = issue_ff[SLOT_BITS-1:0];
   rwot_ram #(.WIDTH(ENTRY_BITS), .DEPTH(TRACK_DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wslot_ff),
      .wr_data({cur_ff.id, cur_ff.start, cur_ff.len}),
      .rd_addr(rd_addr), .rd_data(rd_data));

   logic [63:0] e_id;
   logic [BLOCK_INDEX_BITS-1:0] e_s, e_e, q_e, lo, hi;
   logic [COUNT_BITS-1:0] e_n;
   logic hit;
   logic [MAX_RANGE_BLOCKS-1:0] seg;
   logic [COVER_BITS-1:0] ofs_lo, ofs_hi;
   logic full_ring, all_cov;
   logic [MAX_RANGE_BLOCKS-1:0] need;

   always_comb begin
      e_id = rd_data[ENTRY_BITS-1 -: 64];
      e_s = rd_data[COUNT_BITS +: BLOCK_INDEX_BITS];
      e_n = rd_data[COUNT_BITS-1:0];
      e_e = e_s + BLOCK_INDEX_BITS'(e_n) - 1'b1;
      q_e = cur_ff.start + BLOCK_INDEX_BITS'(cur_ff.len) - 1'b1;
      hit = (e_id > cur_ff.id) && !(e_s > q_e || cur_ff.start > e_e);
      lo = (e_s > cur_ff.start) ? e_s : cur_ff.start;
      hi = (e_e < q_e) ? e_e : q_e;
      ofs_lo = COVER_BITS'(lo - cur_ff.start);
      ofs_hi = COVER_BITS'(hi - cur_ff.start);
      for (int k = 0; k < MAX_RANGE_BLOCKS; k++)
         seg[k] = (COVER_BITS'(k) >= ofs_lo) && (COVER_BITS'(k) <= ofs_hi);
      for (int k = 0; k < MAX_RANGE_BLOCKS; k++)
         need[k] = COVER_BITS'(k) < COVER_BITS'(cur_ff.len);
      full_ring = fill_ff == FILL_BITS'(TRACK_DEPTH);
      all_cov = (cover_ff & need) == need;
   end

   always_comb begin
      out_in = '0;
      case (cur_ff.op)
         OP_CHECK: begin
            if (cur_ff.id == '0) out_in.status = ST_NONE;
            else if (full_ring && cur_ff.id < min_ff) out_in.status = ST_TOO_OLD;
            else if (dup_ff) out_in.status = ST_REPEATED;
            else if (larger_ff && found_ff) begin
               out_in.status = all_cov ? ST_COMPLETE : ST_PARTIAL;
               out_in.overlap_id = best_id_ff;
               out_in.overlap_start = best_start_ff;
               out_in.overlap_count = best_cnt_ff;
            end else out_in.status = ST_NONE;
         end
         OP_ADD: begin
            if (cur_ff.id == '0) out_in.status = ST_CLEARED;
            else if (dup_ff) out_in.status = ST_DUPLICATE;
            else begin
               out_in.status = ST_RECORDED;
               if (full_ring) begin
                  out_in.evicted = 1'b1;
                  out_in.evicted_id = old_id_ff;
               end
            end
         end
         OP_CLEAR: out_in.status = ST_CLEARED;
         default: out_in.status = ST_NONE;
      endcase
   end

   assign wr_en = state_ff == S_DONE && cur_ff.op == OP_ADD && cur_ff.id != '0 && !dup_ff;
   assign job_take = state_ff == S_IDLE && job_valid;
   assign idle = state_ff == S_IDLE;
   assign rsp_valid = out_v_ff;
   assign rsp_data = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wslot_ff <= '0;
         fill_ff <= '0;
         out_v_ff <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         out_v_ff <= state_ff == S_DONE;
         case (state_ff)
            S_IDLE: begin
               if (job_valid) begin
                  cur_ff <= job;
                  issue_ff <= '0;
                  rvalid_ff <= 1'b0;
                  min_ff <= '1;
                  found_ff <= 1'b0;
                  larger_ff <= 1'b0;
                  dup_ff <= 1'b0;
                  cover_ff <= '0;
                  best_id_ff <= '0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               rvalid_ff <= issue_ff < CNT_BITS'(fill_ff);
               if (issue_ff < CNT_BITS'(fill_ff)) begin
                  issue_ff <= issue_ff + 1'b1;
                  rd_slot_ff <= rd_addr;
               end
               if (rvalid_ff) begin
                  if (e_id < min_ff) min_ff <= e_id;
                  if (e_id == cur_ff.id) dup_ff <= 1'b1;
                  if (rd_slot_ff == wslot_ff) old_id_ff <= e_id;
                  if (e_id > cur_ff.id) larger_ff <= 1'b1;
                  if (hit) begin
                     cover_ff <= cover_ff | seg;
                     if (!found_ff || e_id > best_id_ff) begin
                        found_ff <= 1'b1;
                        best_id_ff <= e_id;
                        best_start_ff <= e_s;
                        best_cnt_ff <= e_n;
                     end
                  end
               end
               if (!rvalid_ff && issue_ff >= CNT_BITS'(fill_ff)) state_ff <= S_DONE;
            end
            S_DONE: begin
               out_ff <= out_in;
               state_ff <= S_IDLE;
               if (wr_en) begin
                  if (!full_ring) fill_ff <= fill_ff + 1'b1;
                  wslot_ff <= (wslot_ff == SLOT_BITS'(TRACK_DEPTH - 1)) ?
                              '0 : wslot_ff + 1'b1;
               end else if (cur_ff.op == OP_CLEAR) begin
                  fill_ff <= '0;
                  wslot_ff <= '0;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `ASSERT_IMPL(a_fill_cap, 1'b1, fill_ff <= FILL_BITS'(TRACK_DEPTH), "fill overflow")
   `ASSERT_NEXT(a_done_rsp, state_ff == S_DONE, out_v_ff && state_ff == S_IDLE,
                "no response")
endmodule

/* design/recent_write_overlap_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recent_write_overlap_tracker
// Ring of recent write requests with overlap check, add and clear.
// ----------------------------------------------------------------------------
// Path: front job register, then the back end states S_SCAN and S_DONE, then the
// registered rsp_valid. A new request is taken only while the front holds no job
// and the back end is idle; the entry scan reads one ring slot a cycle from the entry RAM.
// Reset: synchronous; the ring is empty after reset, busy low.
// The receiver cannot stall: rsp_valid lasts one cycle.
module recent_write_overlap_tracker import rwot_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);
   logic    job_valid, job_take, back_idle;
   job_type job;

   rwot_front u_front (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data), .busy(busy),
      .job_valid(job_valid), .job(job), .job_take(job_take), .back_idle(back_idle));

   rwot_back u_back (
      .clock(clock), .reset(reset), .job_valid(job_valid), .job(job),
      .job_take(job_take), .idle(back_idle), .rsp_valid(rsp_valid),
      .rsp_data(rsp_data));
endmodule

/* test/recent_write_overlap_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recent_write_overlap_checker
// Watches the request and response channels of the overlap tracker, keeps a
// shadow ring of recorded writes, predicts each response and compares it
// field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module recent_write_overlap_checker import rwot_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   output int      pending,
   output int      errors
);
   logic [63:0] ring_id    [TRACK_DEPTH];
   logic [63:0] ring_start [TRACK_DEPTH];
   logic [63:0] ring_count [TRACK_DEPTH];
   int          next_slot;
   int          used;
   rsp_type     awaited_rsp[$];

   function automatic int slot_of(logic [63:0] id);
      for (int i = 0; i < used; i++)
         if (ring_id[i] == id) return i;
      return -1;
   endfunction

   function automatic rsp_type predict_response(req_type r);
      rsp_type              o;
      logic [63:0]          top, s, n, fin, es, ee, lo, hi, low_id, best_id;
      logic [MAX_RANGE_BLOCKS-1:0] covered;
      int                   best, tally;
      bit                   any_larger;
      o = '0;
      top = (64'd1 << BLOCK_INDEX_BITS) - 1;
      s = 64'(r.range_start);
      n = 64'(r.block_count);
      if (n == 0) n = 1;
      if (n > MAX_RANGE_BLOCKS) n = MAX_RANGE_BLOCKS;
      if (s > top - (n - 1)) n = top - s + 1;
      fin = s + n - 1;
      case (op_type'(r.operation))
         OP_CHECK: begin
            o.status = ST_NONE;
            if (r.request_id == 0) return o;
            if (used >= TRACK_DEPTH) begin
               low_id = '1;
               for (int i = 0; i < TRACK_DEPTH; i++)
                  if (ring_id[i] < low_id) low_id = ring_id[i];
               if (r.request_id < low_id) begin
                  o.status = ST_TOO_OLD;
                  return o;
               end
            end
            if (slot_of(r.request_id) >= 0) begin
               o.status = ST_REPEATED;
               return o;
            end
            covered = '0;
            best = -1;
            best_id = 0;
            any_larger = 0;
            for (int i = 0; i < used; i++) begin
               es = ring_start[i];
               ee = es + ring_count[i] - 1;
               if (ring_id[i] <= r.request_id) continue;
               any_larger = 1;
               if (es > fin || s > ee) continue;
               lo = (es > s) ? es : s;
               hi = (ee < fin) ? ee : fin;
               for (logic [63:0] k = lo - s; k <= hi - s && k < MAX_RANGE_BLOCKS; k++)
                  covered[k] = 1'b1;
               if (best < 0 || ring_id[i] > best_id) begin
                  best = i;
                  best_id = ring_id[i];
               end
            end
            if (!any_larger || best < 0) return o;
            o.overlap_id = best_id;
            o.overlap_start = ring_start[best][47:0];
            o.overlap_count = ring_count[best][10:0];
            tally = $countones(covered);
            o.status = (tally >= n) ? ST_COMPLETE : ST_PARTIAL;
         end
         OP_ADD: begin
            if (r.request_id == 0) begin
               o.status = ST_CLEARED;
               return o;
            end
            if (slot_of(r.request_id) >= 0) begin
               o.status = ST_DUPLICATE;
               return o;
            end
            if (used >= TRACK_DEPTH) begin
               o.evicted = 1'b1;
               o.evicted_id = ring_id[next_slot];
            end else begin
               used++;
            end
            ring_id[next_slot] = r.request_id;
            ring_start[next_slot] = s;
            ring_count[next_slot] = n;
            next_slot = (next_slot + 1) % TRACK_DEPTH;
            o.status = ST_RECORDED;
         end
         OP_CLEAR: begin
            next_slot = 0;
            used = 0;
            o.status = ST_CLEARED;
         end
         default: o.status = ST_NONE;
      endcase
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         next_slot = 0;
         used = 0;
         awaited_rsp.delete();
         errors <= 0;
      end else begin
         if (rsp_valid) begin
            if (awaited_rsp.size() == 0) begin
               if (errors < 10) $display("unexpected response %p", rsp_data);
               errors <= errors + 1;
            end else begin
               want = awaited_rsp.pop_front();
               if (want.status !== rsp_data.status ||
                   want.overlap_id !== rsp_data.overlap_id ||
                   want.overlap_start !== rsp_data.overlap_start ||
                   want.overlap_count !== rsp_data.overlap_count ||
                   want.evicted !== rsp_data.evicted ||
                   want.evicted_id !== rsp_data.evicted_id) begin
                  if (errors < 10)
                     $display("mismatch: expected %p actual %p", want, rsp_data);
                  errors <= errors + 1;
               end
            end
         end
         if (start && !busy) awaited_rsp.push_back(predict_response(req_data));
      end
      pending = awaited_rsp.size();
   end
endmodule

/* test/tb_recent_write_overlap_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_recent_write_overlap_tracker
// Drives directed and random check, add, clear and no-op requests into the overlap
// tracker with varying sender gaps; a checker beside the block predicts and
// compares every response, and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_recent_write_overlap_tracker;
   import rwot_pkg::*;

   localparam int IDLE_LIMIT = 2000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      pending, errors, quiet_cycles = 0, gap_pct = 0;
   logic [63:0] id_base = 64'd1000;
   logic [47:0] start_base = 48'd0;

   always #4 clock = ~clock;

   recent_write_overlap_tracker dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data));

   recent_write_overlap_checker checker_inst (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .pending(pending), .errors(errors));

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send(op_type op, logic [63:0] id, logic [47:0] first,
                       logic [10:0] count);
      start <= 1'b1;
      req_data <= '{operation: op, request_id: id, range_start: first,
                    block_count: count};
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      if ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic random_request();
      op_type      op;
      logic [63:0] id;
      logic [47:0] first;
      logic [10:0] count;
      int          pick;
      pick = $urandom_range(99);
      op = (pick < 48) ? OP_CHECK : (pick < 94) ? OP_ADD : (pick < 97) ? OP_CLEAR : OP_NONE;
      if (op == OP_ADD) id_base = id_base + $urandom_range(1, 4);
      id = id_base - $urandom_range(0, 24);
      if ($urandom_range(99) < 4) id = 0;
      if ($urandom_range(99) < 4) id = {$urandom, $urandom};
      if ($urandom_range(99) < 5) start_base = 48'({$urandom, $urandom});
      first = start_base + $urandom_range(0, 1500);
      count = 11'($urandom_range(1, 64));
      if ($urandom_range(99) < 15) count = 11'($urandom_range(0, 2047));
      send(op, id, first, count);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send(OP_CLEAR, 64'd0, 48'd0, 11'd1);
      send(OP_CHECK, 64'd0, 48'd0, 11'd1);
      send(OP_CHECK, 64'd5, 48'd0, 11'd4);
      send(OP_ADD, 64'd0, 48'd0, 11'd4);
      send(OP_ADD, 64'd10, 48'd100, 11'd10);
      send(OP_ADD, 64'd10, 48'd100, 11'd10);
      send(OP_ADD, 64'd20, 48'd105, 11'd20);
      send(OP_CHECK, 64'd10, 48'd0, 11'd4);
      send(OP_CHECK, 64'd5, 48'd100, 11'd10);
      send(OP_CHECK, 64'd5, 48'd95, 11'd10);
      send(OP_CHECK, 64'd5, 48'd0, 11'd50);
      send(OP_CHECK, 64'd25, 48'd100, 11'd10);
      send(OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFF0, 11'd1024);
      send(OP_ADD, 64'd30, 48'd500, 11'd0);
      send(OP_ADD, 64'd31, 48'd600, 11'd2047);
      send(OP_CHECK, 64'd1, 48'hFFFF_FFFF_FFFF, 11'd2047);
      send(OP_NONE, 64'd40, 48'd100, 11'd10);
      for (int i = 0; i < 12; i++) send(OP_ADD, 64'd50 + i, 48'd700 + 4 * i, 11'd8);
      send(OP_CHECK, 64'd2, 48'd0, 11'd4);
      send(OP_ADD, 64'd70, 48'd800, 11'd5);
      send(OP_CHECK, 64'd55, 48'd700, 11'd48);
      drain();
      send(OP_CLEAR, 64'd0, 48'd0, 11'd0);

      gap_pct = 25;
      repeat (130) random_request();
      drain();
      gap_pct = 67;
      repeat (130) random_request();
      gap_pct = 0;
      repeat (140) random_request();

      drain();
      repeat (40) @(posedge clock);
      if (errors == 0 && pending == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
